### rtl/core/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types, widths and codes for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

   // Field widths of the request and response transactions
   localparam int DATA_W = 32;
   localparam int OP_W   = 3;
   localparam int POS_W  = 9;
   localparam int LEN_W  = 9;
   localparam int ST_W   = 2;

   // Default list depth
   localparam int PLE_CAPACITY = 256;

   // Operation codes
   localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE  = 3'd1;
   localparam logic [OP_W-1:0] OP_GET     = 3'd2;
   localparam logic [OP_W-1:0] OP_REPLACE = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

   // Response status codes
   localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [POS_W-1:0]  position;
      logic [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic              ok;
      logic [ST_W-1:0]   status;
      logic [DATA_W-1:0] data_out;
      logic [LEN_W-1:0]  length;
      logic              empty_res;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic judge;
      logic step;
      logic read_slot;
      logic take_data;
      logic put_value;
      logic inc_count;
      logic dec_count;
      logic clear_count;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            go;
      logic            walk_more;
   } dp_status_type;

endpackage

### rtl/core/ple_ram.sv
// ----------------------------------------------------------------------------
// ple_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ple_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### rtl/core/ple_datapath.sv
// ----------------------------------------------------------------------------
// ple_datapath
// Request register, length counter, walk cursor, entry store and result
// registers of the positional list engine.
// ----------------------------------------------------------------------------
module ple_datapath #(
   parameter int CAPACITY = ple_pkg::PLE_CAPACITY
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ple_pkg::dp_cmd_type    cmd,
   input  ple_pkg::req_type       req_item,
   output ple_pkg::dp_status_type dp_status,
   output ple_pkg::rsp_type       rsp_item
);
   import ple_pkg::*;

   localparam int AW    = $clog2(CAPACITY);
   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((CW > POS_W) ? CW : POS_W) + 1;

   req_type           req_ff;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     ptr_ff, ptr_in;
   logic              pend_ff;
   logic [AW-1:0]     pend_addr_ff;
   logic              ok_ff;
   logic [ST_W-1:0]   status_ff;
   logic [DATA_W-1:0] data_ff;

   logic [CMP_W-1:0]  pos_x, cnt_x, ptr_x, slot_x, next_rd_x;
   logic              pos_nz, full, in_list, ins_pos_ok;
   logic              go_c, walk_more;
   logic [ST_W-1:0]   st_c;
   logic              is_insert;

   logic              ram_wr_en, ram_rd_en;
   logic [AW-1:0]     ram_wr_addr, ram_rd_addr;
   logic [DATA_W-1:0] ram_wr_data, ram_rd_data;

   // Compare domain wide enough for both position and length
   assign pos_x     = CMP_W'(req_ff.position);
   assign cnt_x     = CMP_W'(count_ff);
   assign ptr_x     = CMP_W'(ptr_ff);
   assign slot_x    = pos_x - CMP_W'(1);
   assign is_insert = (req_ff.operation == OP_INSERT);

   assign pos_nz     = (req_ff.position != '0);
   assign full       = (cnt_x >= CMP_W'(CAPACITY));
   assign in_list    = pos_nz && (pos_x <= cnt_x);
   assign ins_pos_ok = pos_nz && (pos_x <= (cnt_x + CMP_W'(1)));

   // Outcome of the registered request against the current length
   always_comb begin
      go_c = 1'b0;
      st_c = ST_RANGE;
      case (req_ff.operation)
         OP_INSERT: begin
            if (full) begin
               st_c = ST_FULL;
            end else if (ins_pos_ok) begin
               go_c = 1'b1;
               st_c = ST_DONE;
            end
         end
         OP_REMOVE, OP_GET, OP_REPLACE: begin
            if (in_list) begin
               go_c = 1'b1;
               st_c = ST_DONE;
            end
         end
         OP_CLEAR: begin
            go_c = 1'b1;
            st_c = ST_DONE;
         end
         default: begin
            go_c = 1'b0;
            st_c = ST_RANGE;
         end
      endcase
   end

   // Insert walks down from the tail, remove walks up from the hole
   assign walk_more = is_insert ? (ptr_x > slot_x) : ((ptr_x + CMP_W'(1)) < cnt_x);
   assign next_rd_x = is_insert ? (ptr_x - CMP_W'(1)) : (ptr_x + CMP_W'(1));

   assign dp_status.op        = req_ff.operation;
   assign dp_status.go        = go_c;
   assign dp_status.walk_more = walk_more;

   // Store port usage: a pending shift write wins, the controller keeps
   // value writes apart from it
   assign ram_rd_en   = cmd.step || cmd.read_slot;
   assign ram_rd_addr = cmd.step ? next_rd_x[AW-1:0] : slot_x[AW-1:0];
   assign ram_wr_en   = pend_ff || cmd.put_value;
   assign ram_wr_addr = pend_ff ? pend_addr_ff : slot_x[AW-1:0];
   assign ram_wr_data = pend_ff ? ram_rd_data : req_ff.value;

   ple_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Length counter
   always_comb begin
      count_in = count_ff;
      if (cmd.clear_count) begin
         count_in = '0;
      end else if (cmd.inc_count) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.dec_count) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         pend_ff  <= cmd.step;
      end
   end

   // Walk cursor
   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.judge) begin
         ptr_in = is_insert ? count_ff : slot_x[CW-1:0];
      end else if (cmd.step) begin
         ptr_in = next_rd_x[CW-1:0];
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (cmd.step) begin
         pend_addr_ff <= ptr_ff[AW-1:0];
      end
      if (cmd.load) begin
         req_ff <= req_item;
      end
      if (cmd.judge) begin
         ok_ff     <= go_c;
         status_ff <= st_c;
         data_ff   <= '0;
      end else if (cmd.take_data) begin
         data_ff <= ram_rd_data;
      end
   end

   assign rsp_item.ok        = ok_ff;
   assign rsp_item.status    = status_ff;
   assign rsp_item.data_out  = data_ff;
   assign rsp_item.length    = LEN_W'(count_ff);
   assign rsp_item.empty_res = (count_ff == '0);

endmodule

### rtl/core/ple_ctrl.sv
// ----------------------------------------------------------------------------
// ple_ctrl
// Sequencer of the positional list engine: decides, walks and responds.
// ----------------------------------------------------------------------------
module ple_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  ple_pkg::dp_status_type dp_status,
   output logic                   busy,
   output logic                   rsp_valid,
   output ple_pkg::dp_cmd_type    cmd
);
   import ple_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_CHECK = 7'b0000010,
      S_WALK  = 7'b0000100,
      S_PUT   = 7'b0001000,
      S_READ  = 7'b0010000,
      S_LATCH = 7'b0100000,
      S_RESP  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      load;

   // A new transaction may enter while the previous result is strobed
   assign busy      = !((state_ff == S_IDLE) || (state_ff == S_RESP));
   assign rsp_valid = (state_ff == S_RESP);
   assign load      = start && !busy;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.load = load;
      case (state_ff)
         S_IDLE, S_RESP: begin
            state_in = load ? S_CHECK : S_IDLE;
         end
         // Range check and dispatch
         S_CHECK: begin
            cmd.judge = 1'b1;
            state_in  = S_RESP;
            if (dp_status.go) begin
               case (dp_status.op)
                  OP_CLEAR: begin
                     cmd.clear_count = 1'b1;
                  end
                  OP_INSERT, OP_REMOVE: begin
                     state_in = S_WALK;
                  end
                  OP_GET, OP_REPLACE: begin
                     state_in = S_READ;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         // Shift one entry per cycle; last write lands on the exit cycle
         S_WALK: begin
            if (dp_status.walk_more) begin
               cmd.step = 1'b1;
            end else if (dp_status.op == OP_INSERT) begin
               state_in = S_PUT;
            end else begin
               cmd.dec_count = 1'b1;
               state_in      = S_RESP;
            end
         end
         S_PUT: begin
            cmd.put_value = 1'b1;
            cmd.inc_count = 1'b1;
            state_in      = S_RESP;
         end
         S_READ: begin
            cmd.read_slot = 1'b1;
            state_in      = S_LATCH;
         end
         S_LATCH: begin
            cmd.take_data = 1'b1;
            cmd.put_value = (dp_status.op == OP_REPLACE);
            state_in      = S_RESP;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/positional_list_engine_unit.sv
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Bounded ordered list of up to CAPACITY words addressed by 1-based position.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its single
// result appears on rsp_item for exactly one cycle with rsp_valid high and
// cannot be held off, so the receiver must capture it then. A new request
// may be started in the same cycle the previous result is strobed. Clear
// and any rejected request respond straight after the range check; get and
// replace first read the addressed slot; insert and remove first shift the
// entries behind the position, insert then writing the value. They move one
// entry per cycle through the single store, so the walk over the entries
// behind the position sets the worst case, an insert at position 1 into a
// list holding CAPACITY-1 entries.
// ----------------------------------------------------------------------------
module positional_list_engine_unit #(
   parameter int CAPACITY = ple_pkg::PLE_CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ple_pkg::req_type req_item,
   output logic             rsp_valid,
   output ple_pkg::rsp_type rsp_item
);
   import ple_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type dp_status;

   ple_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .dp_status (dp_status),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   ple_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_item  (req_item),
      .dp_status (dp_status),
      .rsp_item  (rsp_item)
   );

endmodule

### rtl/core/ple_checker.sv
// ----------------------------------------------------------------------------
// ple_checker
// Port-level checks on the positional list engine, bound to the top level.
// ----------------------------------------------------------------------------
module ple_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input ple_pkg::rsp_type rsp_item
);
   import ple_pkg::*;

   // Each transaction gives one strobe, never two in a row
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for two cycles");

   // An accepted transaction keeps the engine busy in the next cycle
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("engine not busy after accepting a transaction");

   // Empty flag agrees with the reported length
   a_empty_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.empty_res == (rsp_item.length == '0)))
      else $error("empty flag disagrees with length");

   // Success and status agree, failures return no data
   a_ok_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_item.ok == (rsp_item.status == ST_DONE)) &&
                     (rsp_item.ok || (rsp_item.data_out == '0))))
      else $error("ok, status and data_out inconsistent");

endmodule

bind positional_list_engine_unit ple_checker u_ple_checker (.*);

### tb/positional_list_engine_unit_tb.sv
// ----------------------------------------------------------------------------
// positional_list_engine_unit_tb
// Self-checking testbench for the positional list engine.
// A short table of directed requests covers empty-list errors, the extreme
// positions and words, each operation and the unused operation codes. A random
// part follows. It fills the list to capacity, pokes the full list, and then
// runs grow, shrink and mixed phases with a little noise. Each request is
// predicted by a local list model, and each strobed result is compared
// field by field against the oldest pending expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module positional_list_engine_unit_tb;
   import ple_pkg::*;

   localparam int LIST_DEPTH = PLE_CAPACITY;
   // Requests with a real operation code to issue before stopping
   localparam int STIM_ITEMS = 870;
   // Longest walk plus longest sender gap, taken several times over
   localparam int IDLE_LIMIT = 8 * (LIST_DEPTH + 70);

   // Operation codes the block does not implement
   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

   typedef enum {MODE_MIX, MODE_GROW, MODE_SHRINK} mix_mode_type;

   typedef struct packed {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   // Local copy of the list contents and length
   logic [DATA_W-1:0] list_words [LIST_DEPTH];
   int                list_len;

   rsp_type      expect_q [$];
   rsp_type      head_rsp;
   stim_row_type dir_rows [$];

   int  mismatches;
   int  rsp_checked;
   int  work_items;
   int  idle_cycles;
   int  full_refusals;
   int  peak_len;
   int  op_tally [8];
   bit  no_idle;

   positional_list_engine_unit uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Predict one request and update the local list
   function automatic rsp_type predict_list_op(input req_type r);
      rsp_type e;
      bit      in_list;
      int      slot;
      e.ok       = 1'b0;
      e.status   = ST_RANGE;
      e.data_out = '0;
      in_list    = (r.position >= 1) && (r.position <= list_len);
      slot       = int'(r.position) - 1;
      case (r.operation)
         OP_INSERT: begin
            if (list_len >= LIST_DEPTH) begin
               e.status = ST_FULL;
            end else if (r.position >= 1 && r.position <= list_len + 1) begin
               for (int k = list_len; k > slot; k--)
                  list_words[k] = list_words[k-1];
               list_words[slot] = r.value;
               list_len++;
               e.ok     = 1'b1;
               e.status = ST_DONE;
            end
         end
         OP_REMOVE: begin
            if (in_list) begin
               for (int k = slot; k + 1 < list_len; k++)
                  list_words[k] = list_words[k+1];
               list_len--;
               e.ok     = 1'b1;
               e.status = ST_DONE;
            end
         end
         OP_GET: begin
            if (in_list) begin
               e.data_out = list_words[slot];
               e.ok       = 1'b1;
               e.status   = ST_DONE;
            end
         end
         OP_REPLACE: begin
            if (in_list) begin
               e.data_out       = list_words[slot];
               list_words[slot] = r.value;
               e.ok             = 1'b1;
               e.status         = ST_DONE;
            end
         end
         OP_CLEAR: begin
            list_len = 0;
            e.ok     = 1'b1;
            e.status = ST_DONE;
         end
         default: ;
      endcase
      e.length    = list_len[LEN_W-1:0];
      e.empty_res = (list_len == 0);
      return e;
   endfunction

   function automatic stim_row_type mk_row(input logic [OP_W-1:0] op, input int pos,
                                           input logic [DATA_W-1:0] val, input bit typed,
                                           input bit ok, input logic [ST_W-1:0] st,
                                           input int len);
      stim_row_type row;
      row.req.operation = op;
      row.req.position  = pos[POS_W-1:0];
      row.req.value     = val;
      row.typed         = typed;
      row.rsp.ok        = ok;
      row.rsp.status    = st;
      row.rsp.data_out  = '0;
      row.rsp.length    = len[LEN_W-1:0];
      row.rsp.empty_res = (len == 0);
      return row;
   endfunction

   // Mostly random words, sometimes all zeros or all ones
   function automatic logic [DATA_W-1:0] pick_word();
      int roll;
      roll = $urandom_range(0, 15);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return $urandom;
   endfunction

   // Sender gap: mostly short, a few long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Mostly well-formed requests against the current length, plus noise
   function automatic req_type pick_request(input mix_mode_type mode);
      req_type r;
      int      roll;
      int      top;
      r.value = pick_word();
      roll    = $urandom_range(0, 99);
      if (roll < 8) begin
         // noise: any code at any position
         r.operation = OP_W'($urandom_range(0, 7));
         r.position  = POS_W'($urandom_range(0, 511));
         return r;
      end
      roll = $urandom_range(0, 99);
      case (mode)
         MODE_GROW:
            r.operation = (roll < 70) ? OP_INSERT : (roll < 80) ? OP_GET :
                          (roll < 90) ? OP_REPLACE : OP_REMOVE;
         MODE_SHRINK:
            r.operation = (roll < 65) ? OP_REMOVE : (roll < 80) ? OP_GET :
                          (roll < 95) ? OP_REPLACE : OP_INSERT;
         default:
            r.operation = (roll < 30) ? OP_INSERT : (roll < 55) ? OP_REMOVE :
                          (roll < 76) ? OP_GET : (roll < 97) ? OP_REPLACE : OP_CLEAR;
      endcase
      // insert may also land just past the tail
      top  = (r.operation == OP_INSERT) ? list_len + 1 : list_len;
      roll = $urandom_range(0, 99);
      if (roll < 4)
         r.position = '0;
      else if (roll < 6 || top == 0)
         r.position = POS_W'(top + 1);
      else if (roll < 8)
         r.position = POS_W'($urandom_range(top + 1, 511));
      else
         r.position = POS_W'($urandom_range(1, top));
      return r;
   endfunction

   // Issue one transaction and record its expected result at acceptance
   task automatic send_request(input req_type r, input bit typed, input rsp_type typed_rsp);
      int      gap;
      rsp_type pred;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      pred = predict_list_op(r);
      expect_q.push_back(typed ? typed_rsp : pred);
      op_tally[r.operation]++;
      if (r.operation <= OP_CLEAR) work_items++;
      if (pred.status == ST_FULL) full_refusals++;
      if (list_len > peak_len) peak_len = list_len;
      @(negedge clock);
   endtask

   task automatic report_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expect_q.size() == 0) begin
            $display("%0t: result with no pending transaction, expected none, actual %h",
                     $time, rsp_item);
            mismatches++;
         end else begin
            head_rsp = expect_q.pop_front();
            report_field("ok", DATA_W'(head_rsp.ok), DATA_W'(rsp_item.ok));
            report_field("status", DATA_W'(head_rsp.status), DATA_W'(rsp_item.status));
            report_field("data_out", head_rsp.data_out, rsp_item.data_out);
            report_field("length", DATA_W'(head_rsp.length), DATA_W'(rsp_item.length));
            report_field("empty_res", DATA_W'(head_rsp.empty_res),
                         DATA_W'(rsp_item.empty_res));
         end
         rsp_checked++;
      end
   end

   // Watchdog on cycles without any accepted transaction or strobed result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: watchdog, no transaction for %0d cycles", $time, idle_cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   // Stimulus
   initial begin
      mix_mode_type mode;
      int           run_len;
      req_type      r;

      reset         = 1'b1;
      start         = 1'b0;
      req_item      = '0;
      list_len      = 0;
      mismatches    = 0;
      rsp_checked   = 0;
      work_items    = 0;
      full_refusals = 0;
      peak_len      = 0;
      no_idle       = 1'b0;
      foreach (op_tally[i]) op_tally[i] = 0;

      // directed table: typed rows are read straight off the spec
      dir_rows.push_back(mk_row(OP_GET,     1,   '0,           1, 0, ST_RANGE, 0));
      dir_rows.push_back(mk_row(OP_REMOVE,  1,   '0,           1, 0, ST_RANGE, 0));
      dir_rows.push_back(mk_row(OP_REPLACE, 0,   '1,           1, 0, ST_RANGE, 0));
      dir_rows.push_back(mk_row(OP_INSERT,  0,   '1,           1, 0, ST_RANGE, 0));
      dir_rows.push_back(mk_row(OP_INSERT,  2,   '1,           1, 0, ST_RANGE, 0));
      dir_rows.push_back(mk_row(OP_SPARE_A, 1,   '1,           1, 0, ST_RANGE, 0));
      dir_rows.push_back(mk_row(OP_CLEAR,   0,   '0,           1, 1, ST_DONE,  0));
      dir_rows.push_back(mk_row(OP_INSERT,  1,   '1,           1, 1, ST_DONE,  1));
      dir_rows.push_back(mk_row(OP_INSERT,  2,   '0,           1, 1, ST_DONE,  2));
      dir_rows.push_back(mk_row(OP_INSERT,  1,   32'hA5A5A5A5, 0, 0, ST_DONE,  0));
      dir_rows.push_back(mk_row(OP_INSERT,  4,   32'h5A5A5A5A, 0, 0, ST_DONE,  0));
      dir_rows.push_back(mk_row(OP_INSERT,  6,   '1,           1, 0, ST_RANGE, 4));
      dir_rows.push_back(mk_row(OP_GET,     1,   '0,           0, 0, ST_DONE,  0));
      dir_rows.push_back(mk_row(OP_GET,     4,   '1,           0, 0, ST_DONE,  0));
      dir_rows.push_back(mk_row(OP_REPLACE, 2,   32'h12345678, 0, 0, ST_DONE,  0));
      dir_rows.push_back(mk_row(OP_GET,     2,   '0,           0, 0, ST_DONE,  0));
      dir_rows.push_back(mk_row(OP_REPLACE, 5,   '1,           1, 0, ST_RANGE, 4));
      dir_rows.push_back(mk_row(OP_GET,     511, '0,           1, 0, ST_RANGE, 4));
      dir_rows.push_back(mk_row(OP_REMOVE,  0,   '0,           1, 0, ST_RANGE, 4));
      dir_rows.push_back(mk_row(OP_REMOVE,  2,   '0,           0, 0, ST_DONE,  0));
      dir_rows.push_back(mk_row(OP_REMOVE,  3,   '0,           0, 0, ST_DONE,  0));
      dir_rows.push_back(mk_row(OP_SPARE_B, 511, '1,           1, 0, ST_RANGE, 2));
      dir_rows.push_back(mk_row(OP_SPARE_C, 2,   '0,           1, 0, ST_RANGE, 2));
      dir_rows.push_back(mk_row(OP_CLEAR,   511, '1,           1, 1, ST_DONE,  0));
      dir_rows.push_back(mk_row(OP_GET,     1,   '0,           1, 0, ST_RANGE, 0));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

      // fill to capacity at random positions
      while (list_len < LIST_DEPTH) begin
         r.operation = OP_INSERT;
         r.position  = POS_W'($urandom_range(1, list_len + 1));
         r.value     = pick_word();
         send_request(r, 1'b0, '0);
      end

      // work around the full list: refused inserts, tail accesses
      repeat (40) send_request(pick_request(MODE_MIX), 1'b0, '0);

      // random phases of varying mix, some without sender gaps
      while (work_items < STIM_ITEMS) begin
         mode    = mix_mode_type'($urandom_range(0, 2));
         run_len = $urandom_range(30, 100);
         no_idle = ($urandom_range(0, 4) == 0);
         repeat (run_len) send_request(pick_request(mode), 1'b0, '0);
      end
      no_idle = 1'b0;
      start <= 1'b0;

      while (expect_q.size() != 0) @(posedge clock);
      repeat (LIST_DEPTH + 8) @(posedge clock);

      $display({"Run covered %0d requests: %0d insert, %0d remove, %0d get, ",
                "%0d replace, %0d clear, %0d unused codes"},
               work_items + op_tally[5] + op_tally[6] + op_tally[7], op_tally[0],
               op_tally[1], op_tally[2], op_tally[3], op_tally[4],
               op_tally[5] + op_tally[6] + op_tally[7]);
      $display("Peak length %0d of %0d, %0d inserts refused on a full list, %0d results checked",
               peak_len, LIST_DEPTH, full_refusals, rsp_checked);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
